FILE: src/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
package mbps_pkg;

    localparam int LEN_W  = 5;
    localparam int ADDR_W = 32;
    localparam int CFG_W  = 64;
    localparam int MASK_W = 16;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_BASE         = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_out_word;

    typedef struct packed {
        t_reg_idx         index;
        logic [CFG_W-1:0] value;
    } t_cfg_word;

endpackage

FILE: src/mbps_chan_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
interface mbps_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/masked_byte_pattern_search_top.sv
// Top level of the masked byte pattern search block.
// Scans a memory image one byte per cycle (last_byte flags the final byte) against a
// pattern of up to MAX_PATTERN bytes with a per-byte wildcard mask, and emits one word on
// the final byte: found, and image_base plus the first match offset (0 when not found).
// Every start position is tried, including the last one. The window compare and count
// update sit between the scan state registers, and the result
// sits in an output register, so a byte is accepted every cycle unless a finished result
// is still waiting while the output side stalls. Configuration writes are always taken
// and should be made between images; the scan state clears itself after each image.
module masked_byte_pattern_search_top #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mbps_chan_if.sink          i_in,
    mbps_chan_if.source        o_out,
    mbps_chan_if.sink          i_cfg
);
    import mbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // configuration
    logic [CFG_W-1:0]  r_pat_low;
    logic [CFG_W-1:0]  r_pat_high;
    logic [MASK_W-1:0] r_wild;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_base;

    // scan state, r_window[0] is the newest byte
    logic [7:0]             r_window [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] r_count;
    logic                   r_match_seen;
    logic [OFFSET_BITS-1:0] r_offset;

    logic      r_out_valid;
    t_out_word r_out;

    logic [7:0]             n_window [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] n_count;
    logic                   n_match_seen;
    logic [OFFSET_BITS-1:0] n_offset;

    t_in_word          in_word;
    t_cfg_word         cfg_word;
    logic              in_acc;
    logic [LEN_W-1:0]  len_used;
    logic [LEN_W-1:0]  pos;
    logic [127:0]      pat_all;
    logic              hit;

    assign in_word  = i_in.data;
    assign cfg_word = i_cfg.data;
    assign pat_all  = {r_pat_high, r_pat_low};

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign in_acc      = i_in.valid && i_in.ready;

    always_comb begin
        if (r_len == '0) begin
            len_used = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            len_used = LEN_W'(MAX_PATTERN);
        end else begin
            len_used = r_len;
        end
    end

    always_comb begin
        n_window[0] = in_word.image_byte;
        for (int p = 1; p < MAX_PATTERN; p++) begin
            n_window[p] = r_window[p-1];
        end

        n_count = (r_count == '1) ? r_count : r_count + OFFSET_BITS'(1);

        // pattern byte j lines up with window position len-1-j
        hit = 1'b1;
        pos = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pos = len_used - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < len_used && !r_wild[j]) begin
                if (n_window[pos[IDX_W-1:0]] != pat_all[j*8 +: 8]) begin
                    hit = 1'b0;
                end
            end
        end

        n_match_seen = r_match_seen;
        n_offset     = r_offset;
        if (!r_match_seen && n_count >= OFFSET_BITS'(len_used) && hit) begin
            n_match_seen = 1'b1;
            n_offset     = n_count - OFFSET_BITS'(len_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_wild     <= '0;
            r_len      <= LEN_W'(1);
            r_base     <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (cfg_word.index)
                REG_PATTERN_LOW:  r_pat_low  <= cfg_word.value;
                REG_PATTERN_HIGH: r_pat_high <= cfg_word.value;
                REG_WILDCARD:     r_wild     <= cfg_word.value[MASK_W-1:0];
                REG_LENGTH:       r_len      <= cfg_word.value[LEN_W-1:0];
                REG_BASE:         r_base     <= cfg_word.value[ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_PATTERN; p++) begin
                r_window[p] <= '0;
            end
            r_count      <= '0;
            r_match_seen <= 1'b0;
            r_offset     <= '0;
        end else if (in_acc) begin
            if (in_word.last_byte) begin
                for (int p = 0; p < MAX_PATTERN; p++) begin
                    r_window[p] <= '0;
                end
                r_count      <= '0;
                r_match_seen <= 1'b0;
                r_offset     <= '0;
            end else begin
                r_window     <= n_window;
                r_count      <= n_count;
                r_match_seen <= n_match_seen;
                r_offset     <= n_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && in_word.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_word.last_byte) begin
            r_out.found         <= n_match_seen;
            r_out.match_address <= n_match_seen ? r_base + ADDR_W'(n_offset) : '0;
        end
    end

    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_word.last_byte |=> r_out_valid)
        else $error("final byte did not produce a result word");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.found |-> r_out.match_address == '0)
        else $error("match address nonzero without a match");

    a_scan_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_word.last_byte |=> r_count == '0 && !r_match_seen)
        else $error("scan state not cleared after final byte");

    a_offset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_match_seen |-> r_offset == '0)
        else $error("match offset set without a recorded match");

endmodule

FILE: dv/mbps_checker.sv
// Checker for the masked byte pattern search: predicts scan results and compares output words.
`timescale 1ns / 100ps

module mbps_checker
    import mbps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_word i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);

    // shadow registers
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] wild;
    logic [4:0]  pat_len;
    logic [31:0] base;

    // scan state
    logic [7:0]  window [16];
    logic [31:0] seen;
    logic        hit;
    logic [31:0] hit_off;

    t_out_word   scan_verdicts [$];
    int          fail_count = 0;

    task automatic clear_scan();
        int i;
        for (i = 0; i < 16; i++) window[i] = 8'h00;
        seen    = '0;
        hit     = 1'b0;
        hit_off = '0;
    endtask

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%t ERROR: %s", $realtime, msg);
    endtask

    task automatic scan_byte(input t_in_word w);
        int          len;
        int          i;
        int          j;
        logic        ok;
        logic [7:0]  pb;
        t_out_word   res;
        len = (pat_len == 0) ? 1 : ((pat_len > 16) ? 16 : int'(pat_len));
        for (i = 15; i > 0; i--) window[i] = window[i-1];
        window[0] = w.image_byte;
        if (seen != 32'hFFFF_FFFF) seen = seen + 1;
        if (!hit && seen >= len) begin
            ok = 1'b1;
            for (j = 0; j < len; j++) begin
                pb = (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
                // window slot len-1-j holds the byte at start offset + j
                if (!wild[j] && window[len-1-j] != pb) ok = 1'b0;
            end
            if (ok) begin
                hit     = 1'b1;
                hit_off = seen - len;
            end
        end
        if (w.last_byte) begin
            res.found         = hit;
            res.match_address = hit ? base + hit_off : '0;
            scan_verdicts.push_back(res);
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            pat_lo  = '0;
            pat_hi  = '0;
            wild    = '0;
            pat_len = 5'd1;
            base    = '0;
            clear_scan();
            scan_verdicts.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (scan_verdicts.size() == 0) begin
                    flag_error($sformatf("unexpected word found=%0b addr=%h",
                                         i_out_data.found, i_out_data.match_address));
                end else begin
                    exp_w = scan_verdicts.pop_front();
                    if (i_out_data.found !== exp_w.found)
                        flag_error($sformatf("found: expected %0b actual %0b",
                                             exp_w.found, i_out_data.found));
                    if (i_out_data.match_address !== exp_w.match_address)
                        flag_error($sformatf("match_address: expected %h actual %h",
                                             exp_w.match_address,
                                             i_out_data.match_address));
                end
            end
            if (i_in_valid && i_in_ready) scan_byte(i_in_data);
            // a register write applies from the next byte on
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    REG_PATTERN_LOW:  pat_lo  = i_cfg_data.value;
                    REG_PATTERN_HIGH: pat_hi  = i_cfg_data.value;
                    REG_WILDCARD:     wild    = i_cfg_data.value[15:0];
                    REG_LENGTH:       pat_len = i_cfg_data.value[4:0];
                    REG_BASE:         base    = i_cfg_data.value[31:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= scan_verdicts.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the masked byte pattern search: reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_top;
    import mbps_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbps_chan_if #(.T(t_in_word))  in_ch  ();
    mbps_chan_if #(.T(t_out_word)) out_ch ();
    mbps_chan_if #(.T(t_cfg_word)) cfg_ch ();

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int gap_max    = 0;
    int burst_left = 0;

    always #5 i_clk = ~i_clk;

    masked_byte_pattern_search_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mbps_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_data   (cfg_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sender: bursts of random length separated by random gaps
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= t_in_word'{b, last};
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_image(input logic [7:0] img [$]);
        int i;
        for (i = 0; i < img.size(); i++) push_byte(img[i], i == img.size() - 1);
    endtask

    // hold the input until every expected word is out, then idle for the quiet period
    task automatic drain(input int quiet);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (quiet) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= t_cfg_word'{idx, v};
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [15:0] mask, input logic [4:0] len,
                                input logic [31:0] base);
        drain(4);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_WILDCARD, {48'd0, mask});
        write_reg(REG_LENGTH, {59'd0, len});
        write_reg(REG_BASE, {32'd0, base});
        cfg_ch.valid <= 1'b0;
    endtask

    // receiver stall pattern, switching mode every so often
    initial begin : sink_stall
        int mode;
        int left;
        out_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (left % 4 == 0);
            endcase
        end
    end

    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [7:0]  img [$];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] mask;
        logic [4:0]  len_cfg;
        logic [31:0] base;
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        logic [7:0]  pb;
        bit          narrow;
        int          eff;
        int          n;
        int          p;
        int          c;
        int          r;
        int          i;
        int          j;

        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: one-byte pattern of zero, match on the second byte
        img = '{8'h55, 8'h00};
        send_image(img);

        // address wraps past the top; match at the final start position
        program_regs(64'h0000_0000_EFBE_ADDE, 64'h0, 16'h0000, 5'd4, 32'hFFFF_FFFF);
        img = '{8'h11, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_image(img);
        img = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_image(img);

        // length zero acts as one; mask bits past the length are ignored
        program_regs(64'h0000_0000_0000_003F, '1, 16'hFFFE, 5'd0, 32'h0000_1000);
        img = '{8'h00, 8'h3F};
        send_image(img);

        // length above the max clamps to 16; image shorter than that never matches
        program_regs('1, '1, 16'hFFFF, 5'd31, 32'h0);
        img.delete();
        repeat (15) img.push_back(8'hFF);
        send_image(img);

        while (bytes_sent < 1830) begin
            r = $urandom_range(0, 9);
            if (r < 2)      len_cfg = 5'($urandom_range(0, 31));
            else if (r < 3) len_cfg = 5'd16;
            else if (r < 7) len_cfg = 5'($urandom_range(1, 4));
            else            len_cfg = 5'($urandom_range(1, 16));

            // narrow phases draw from two byte values so matches overlap often
            narrow = ($urandom_range(0, 2) == 0);
            sym_a  = 8'($urandom);
            sym_b  = 8'($urandom);
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (narrow) begin
                for (j = 0; j < 8; j++) begin
                    lo[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
                    hi[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
                end
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                lo = '0;
                hi = '0;
            end else if (r == 1) begin
                lo = '1;
                hi = '1;
            end

            r = $urandom_range(0, 9);
            if (r < 4)      mask = 16'h0000;
            else if (r < 7) mask = 16'($urandom & $urandom);
            else if (r < 9) mask = 16'($urandom);
            else            mask = 16'hFFFF;

            r = $urandom_range(0, 5);
            if (r == 0)      base = '0;
            else if (r == 1) base = 32'hFFFF_FFFF - $urandom_range(0, 40);
            else             base = $urandom;

            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            program_regs(lo, hi, mask, len_cfg, base);
            eff = (len_cfg == 0) ? 1 : ((len_cfg > 16) ? 16 : int'(len_cfg));

            repeat ($urandom_range(4, 10)) begin
                if ($urandom_range(0, 19) == 0) drain(0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 100)
                                                 : $urandom_range(1, 40);
                img.delete();
                for (i = 0; i < n; i++)
                    img.push_back(narrow ? ($urandom_range(0, 1) ? sym_a : sym_b)
                                         : 8'($urandom));
                // plant the pattern, sometimes at the last start, sometimes one bit off
                if (n >= eff && $urandom_range(0, 9) < 7) begin
                    p = ($urandom_range(0, 3) == 0) ? n - eff : $urandom_range(0, n - eff);
                    for (j = 0; j < eff; j++) begin
                        pb = (j < 8) ? lo[8*j +: 8] : hi[8*(j-8) +: 8];
                        if (!mask[j]) img[p+j] = pb;
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        c = $urandom_range(0, eff - 1);
                        img[p+c] = img[p+c] ^ (8'h01 << $urandom_range(0, 7));
                    end
                end
                send_image(img);
            end
        end

        drain(4);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mbps_pkg.sv
src/mbps_chan_if.sv
src/masked_byte_pattern_search_top.sv
dv/mbps_checker.sv
dv/tb_top.sv
